// ===== sv/door_opener_controller_assert.svh =====
// assertion macros for the door opener controller
`ifndef DOOR_OPENER_CONTROLLER_ASSERT_SVH
`define DOOR_OPENER_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// check on a given clock and active-low reset
`define DOC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("door opener controller check failed");

// check on the block clock and reset
`define DOC_ASSERT(lbl, prop) \
    `DOC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`else

`define DOC_ASSERT_CLK(lbl, clk, rst_n, prop)

`define DOC_ASSERT(lbl, prop)

`endif

`endif

// ===== sv/doc_pkg.sv =====
package doc_pkg;

    localparam int NUM_TMR   = 5;
    localparam int TMR_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [TMR_W-1:0] t_tick;
    typedef t_tick t_per [NUM_TMR];

    typedef enum logic [2:0] {
        TMR_DEBOUNCE = 3'd0,
        TMR_REMOTE   = 3'd1,
        TMR_MOTOR    = 3'd2,
        TMR_LIGHT    = 3'd3,
        TMR_ALERT    = 3'd4
    } t_tmr;

    typedef enum logic [3:0] {
        MODE_IDLE         = 4'd0,
        MODE_OPENED       = 4'd1,
        MODE_CLOSED       = 4'd2,
        MODE_OPENING      = 4'd3,
        MODE_CLOSING      = 4'd4,
        MODE_STOP_OPENING = 4'd5,
        MODE_STOP_CLOSING = 4'd6,
        MODE_FLOATING     = 4'd7,
        MODE_ERROR        = 4'd8
    } t_mode;

    typedef enum logic [2:0] {
        FUNC_TICK         = 3'd0,
        FUNC_OPEN_LIMIT   = 3'd1,
        FUNC_CLOSED_LIMIT = 3'd2,
        FUNC_BUTTON       = 3'd3,
        FUNC_REMOTE       = 3'd4,
        FUNC_STARTUP      = 3'd5
    } t_func;

    // bit 0 drives up, bit 1 drives down
    typedef enum logic [1:0] {
        RELAY_OFF  = 2'd0,
        RELAY_UP   = 2'd1,
        RELAY_DOWN = 2'd2
    } t_relay;

    localparam t_per PER_RST = '{32'd100, 32'd500, 32'd30000, 32'd300000, 32'd600000};

    // working copy of the controller state while one event is processed
    typedef struct packed {
        t_mode                    mode;
        t_relay                   relay;
        logic                     lamp;
        t_tick [NUM_TMR-1:0]      cnt;
        logic  [NUM_TMR-1:0]      pend;
    } t_ctx;

    typedef struct packed {
        logic  relay_up;
        logic  relay_down;
        logic  lamp;
        t_mode door_state;
        logic  status_pulse;
        logic  alert_pulse;
    } t_res;

    // loading a timer also drops an expiry of it that is still waiting
    function automatic t_ctx f_start(t_ctx c, t_tmr k, t_tick p);
        t_ctx r;
        r         = c;
        r.cnt[k]  = (p == '0) ? t_tick'(1) : p;
        r.pend[k] = 1'b0;
        return r;
    endfunction

    function automatic t_ctx f_stop(t_ctx c, t_tmr k);
        t_ctx r;
        r         = c;
        r.cnt[k]  = '0;
        r.pend[k] = 1'b0;
        return r;
    endfunction

    function automatic t_ctx f_light_on(t_ctx c, t_per per);
        t_ctx r;
        r      = f_start(c, TMR_LIGHT, per[TMR_LIGHT]);
        r.lamp = 1'b1;
        return r;
    endfunction

    function automatic t_ctx f_motor(t_ctx c, t_per per, t_relay dir);
        t_ctx r;
        r       = f_start(c, TMR_MOTOR, per[TMR_MOTOR]);
        r       = f_light_on(r, per);
        r.relay = dir;
        return r;
    endfunction

    function automatic t_ctx f_motor_stop(t_ctx c, t_per per);
        t_ctx r;
        r       = f_stop(c, TMR_MOTOR);
        r       = f_light_on(r, per);
        r.relay = RELAY_OFF;
        return r;
    endfunction

    function automatic t_ctx f_toggle(t_ctx c, t_per per);
        t_ctx r;
        r = f_start(c, TMR_ALERT, per[TMR_ALERT]);
        unique case (r.mode)
            MODE_OPENED, MODE_STOP_OPENING: begin
                r      = f_motor(r, per, RELAY_DOWN);
                r.mode = MODE_CLOSING;
            end
            MODE_OPENING: begin
                r      = f_motor_stop(r, per);
                r.mode = MODE_STOP_OPENING;
            end
            MODE_CLOSING: begin
                r      = f_motor_stop(r, per);
                r.mode = MODE_STOP_CLOSING;
            end
            MODE_ERROR: begin
                r = r;
            end
            default: begin
                r      = f_motor(r, per, RELAY_UP);
                r.mode = MODE_OPENING;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/door_opener_controller.sv =====
// an accepted input transaction's result is registered in the result buffer and driven from there to the output port
// throughput: one transaction per cycle while the input is not stalled; the whole event is one pass of logic
// between the state registers and the result register
// a two-entry result buffer (output register plus skid) takes one more transaction
// after the output stalls, then stalls the input; reset (synchronous, active low): idle,
// relays and lamp off, all timers stopped, periods at their defaults, result buffer empty
`include "door_opener_controller_assert.svh"

module door_opener_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [doc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [doc_pkg::TMR_W-1:0]     i_cfg_data,
    // event channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_func,
    input  logic                          i_open_limit_level,
    input  logic                          i_closed_limit_level,
    input  logic                          i_button_level,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_relay_up,
    output logic                          o_relay_down,
    output logic                          o_lamp,
    output logic [3:0]                    o_door_state,
    output logic                          o_status_pulse,
    output logic                          o_alert_pulse
);
    import doc_pkg::*;

    // controller state
    t_per                r_per;
    t_mode               r_mode;
    t_relay              r_relay;
    logic                r_lamp;
    t_tick [NUM_TMR-1:0] r_cnt;

    // next state from the current event
    t_mode               n_mode;
    t_relay              n_relay;
    logic                n_lamp;
    t_tick [NUM_TMR-1:0] n_cnt;
    t_res                n_res;

    // result buffer: output register plus skid entry
    t_res                r_out;
    logic                r_out_valid;
    t_res                r_skd;
    logic                r_skd_valid;

    logic                in_accept;
    logic                out_take;

    // input only stalls once the skid entry is occupied
    assign o_in_stall = r_skd_valid;
    assign in_accept  = i_in_valid && !r_skd_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    // next-state logic: one event walks through the handlers in order
    always_comb begin
        t_ctx c;
        logic status;
        logic alert;
        logic open_act;
        logic closed_act;
        logic button_act;

        open_act   = !i_open_limit_level;
        closed_act = !i_closed_limit_level;
        button_act = !i_button_level;

        c.mode  = r_mode;
        c.relay = r_relay;
        c.lamp  = r_lamp;
        c.cnt   = r_cnt;
        c.pend  = '0;
        status  = 1'b0;
        alert   = 1'b0;

        unique case (t_func'(i_func))
            FUNC_TICK: begin
                // count down every running timer, mark the ones that just ran out
                for (int k = 0; k < NUM_TMR; k++) begin
                    if (c.cnt[k] != '0) begin
                        c.cnt[k] = c.cnt[k] - t_tick'(1);
                        if (c.cnt[k] == '0) begin
                            c.pend[k] = 1'b1;
                        end
                    end
                end
                // expiries in fixed order; a handler that reloads or stops a later
                // timer cancels that timer's expiry for this tick
                if (c.pend[TMR_DEBOUNCE]) begin
                    c.pend[TMR_DEBOUNCE] = 1'b0;
                    if (button_act) begin
                        c      = f_toggle(c, r_per);
                        status = 1'b1;
                    end
                end
                if (c.pend[TMR_REMOTE]) begin
                    c.pend[TMR_REMOTE] = 1'b0;
                    c      = f_toggle(c, r_per);
                    status = 1'b1;
                end
                if (c.pend[TMR_MOTOR]) begin
                    c.pend[TMR_MOTOR] = 1'b0;
                    // run limit reached: force the relays off
                    c = f_motor_stop(c, r_per);
                end
                if (c.pend[TMR_LIGHT]) begin
                    c.pend[TMR_LIGHT] = 1'b0;
                    c.lamp = 1'b0;
                end
                if (c.pend[TMR_ALERT]) begin
                    c.pend[TMR_ALERT] = 1'b0;
                    // door left alone too long: alert and toggle on its own
                    c      = f_toggle(c, r_per);
                    status = 1'b1;
                    alert  = 1'b1;
                end
            end
            FUNC_OPEN_LIMIT: begin
                if (open_act) begin
                    c      = f_motor_stop(c, r_per);
                    c.mode = MODE_OPENED;
                    status = 1'b1;
                end
            end
            FUNC_CLOSED_LIMIT: begin
                if (closed_act) begin
                    c      = f_motor_stop(c, r_per);
                    c.mode = MODE_CLOSED;
                    c      = f_stop(c, TMR_ALERT);
                    status = 1'b1;
                end
            end
            FUNC_BUTTON: begin
                // recheck the level after the debounce time
                if (button_act) begin
                    c = f_start(c, TMR_DEBOUNCE, r_per[TMR_DEBOUNCE]);
                end
            end
            FUNC_REMOTE: begin
                c = f_start(c, TMR_REMOTE, r_per[TMR_REMOTE]);
            end
            FUNC_STARTUP: begin
                // closed limit wins if both switches read active
                if (open_act) begin
                    c.relay = RELAY_OFF;
                    c.mode  = MODE_OPENED;
                end
                if (closed_act) begin
                    c.relay = RELAY_OFF;
                    c.mode  = MODE_CLOSED;
                end
            end
            default: begin
                c = c;
            end
        endcase

        n_mode  = c.mode;
        n_relay = c.relay;
        n_lamp  = c.lamp;
        n_cnt   = c.cnt;

        n_res.relay_up     = c.relay[0];
        n_res.relay_down   = c.relay[1];
        n_res.lamp         = c.lamp;
        n_res.door_state   = c.mode;
        n_res.status_pulse = status;
        n_res.alert_pulse  = alert;
    end

    // state and period registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per   <= PER_RST;
            r_mode  <= MODE_IDLE;
            r_relay <= RELAY_OFF;
            r_lamp  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            // writes beyond the register list are dropped
            if (i_cfg_we && (int'(i_cfg_index) < NUM_TMR)) begin
                r_per[i_cfg_index] <= i_cfg_data;
            end
            if (in_accept) begin
                r_mode  <= n_mode;
                r_relay <= n_relay;
                r_lamp  <= n_lamp;
                r_cnt   <= n_cnt;
            end
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (r_skd_valid) begin
                // input is stalled; drain the skid entry once the output moves
                if (out_take) begin
                    r_skd_valid <= 1'b0;
                end
            end else if (!r_out_valid || out_take) begin
                r_out_valid <= in_accept;
            end else if (in_accept) begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_take) begin
                r_out <= r_skd;
            end
        end else if (!r_out_valid || out_take) begin
            if (in_accept) begin
                r_out <= n_res;
            end
        end else if (in_accept) begin
            r_skd <= n_res;
        end
    end

    // output drive
    always_comb begin
        o_out_valid    = r_out_valid;
        o_relay_up     = r_out.relay_up;
        o_relay_down   = r_out.relay_down;
        o_lamp         = r_out.lamp;
        o_door_state   = r_out.door_state;
        o_status_pulse = r_out.status_pulse;
        o_alert_pulse  = r_out.alert_pulse;
    end

    // skid entry is only ever filled behind a full output register
    `DOC_ASSERT(a_skid_behind_out, r_skd_valid |-> r_out_valid)
    // an event arriving while the output is held lands in the skid entry
    `DOC_ASSERT(a_skid_fill, (in_accept && r_out_valid && i_out_stall) |=> r_skd_valid)
    // a driven motor always has its run limit timer armed
    `DOC_ASSERT(a_motor_timed, (r_relay != RELAY_OFF) |-> (r_cnt[TMR_MOTOR] != '0))
    // a lit lamp always has its light-off timer armed
    `DOC_ASSERT(a_lamp_timed, r_lamp |-> (r_cnt[TMR_LIGHT] != '0))

endmodule
